// File: rtl/core/kst_pkg.sv
// Shared constants, types and functions for the keyboard scanner with typematic repeat.
package kst_pkg;

   localparam int NUM_KEYS  = 128;
   localparam int KEY_AW    = $clog2(NUM_KEYS);
   localparam int INDEX_W   = 7;
   localparam int LEVEL_W   = 8;
   localparam int MODBYTE_W = 8;
   localparam int TIME_W    = 32;
   localparam int CODE_W    = 8;
   localparam int CSR_W     = 16;
   localparam int MOD_W     = 3;
   localparam int ENTRY_W   = LEVEL_W + TIME_W;
   localparam int XLAT_SIZE = 101;

   localparam logic [CODE_W-1:0] CODE_SHIFT = 8'd134;
   localparam logic [CODE_W-1:0] CODE_CTRL  = 8'd133;
   localparam logic [CODE_W-1:0] CODE_ALT   = 8'd132;

   localparam logic [MOD_W-1:0] MOD_SHIFT = 3'b001;
   localparam logic [MOD_W-1:0] MOD_CTRL  = 3'b010;
   localparam logic [MOD_W-1:0] MOD_ALT   = 3'b100;

   // left and right halves of the modifier byte
   localparam logic [MODBYTE_W-1:0] MASK_SHIFT = 8'h22;
   localparam logic [MODBYTE_W-1:0] MASK_CTRL  = 8'h11;
   localparam logic [MODBYTE_W-1:0] MASK_ALT   = 8'h44;

   typedef enum logic {
      KIND_KEY,
      KIND_MOD
   } kind_type;

   typedef enum logic {
      CSR_REPEAT_DELAY,
      CSR_REPEAT_INTERVAL
   } csr_index_type;

   localparam logic [CSR_W-1:0] RESET_DELAY    = 16'd300;
   localparam logic [CSR_W-1:0] RESET_INTERVAL = 16'd150;

   localparam logic [CODE_W-1:0] XLAT [XLAT_SIZE] = '{
      8'd0, 8'd0, 8'd0, 8'd0,
      8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105,
      8'd106, 8'd107, 8'd108, 8'd109,
      8'd110, 8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118,
      8'd119, 8'd120, 8'd121, 8'd122,
      8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd48,
      8'd13, 8'd27, 8'd127, 8'd9, 8'd32, 8'd45, 8'd61, 8'd91, 8'd93, 8'd92,
      8'd0, 8'd59, 8'd39,
      8'd96, 8'd44, 8'd46, 8'd47, 8'd0,
      8'd135, 8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142, 8'd143,
      8'd144, 8'd145, 8'd146,
      8'd0, 8'd0, 8'd255, 8'd147, 8'd151, 8'd150, 8'd148, 8'd152, 8'd149,
      8'd131, 8'd130, 8'd129, 8'd128,
      8'd0, 8'd47, 8'd42, 8'd45, 8'd43, 8'd13, 8'd49, 8'd50, 8'd51, 8'd52,
      8'd53, 8'd54,
      8'd55, 8'd56, 8'd57, 8'd48, 8'd46, 8'd0
   };

   // stage-one item: key fields, precomputed deadlines and modifier work
   typedef struct packed {
      kind_type            kind;
      logic [KEY_AW-1:0]   idx;
      logic [LEVEL_W-1:0]  lvl;
      logic [CODE_W-1:0]   code;
      logic [TIME_W-1:0]   now;
      logic [TIME_W-1:0]   dl_delay;
      logic [TIME_W-1:0]   dl_interval;
      logic [MOD_W-1:0]    mod_new;
      logic [MOD_W-1:0]    mod_pend;
   } stage_type;

   function automatic logic [CODE_W-1:0] key_code_of(input logic [INDEX_W-1:0] idx);
      logic [CODE_W-1:0] code;
      code = '0;
      if (int'(idx) < XLAT_SIZE) begin
         code = XLAT[idx];
      end
      return code;
   endfunction

   // wrap-safe: deadline strictly earlier than now
   function automatic logic time_passed(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] deadline);
      logic [TIME_W-1:0] diff;
      diff = now - deadline;
      return (diff != '0) && !diff[TIME_W-1];
   endfunction

endpackage

// File: rtl/core/kst_intf.sv
// Request and response channel interfaces of the keyboard scanner.
interface kst_req_if;
   import kst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [INDEX_W-1:0]    scan_index;
   logic [LEVEL_W-1:0]    key_level;
   logic [MODBYTE_W-1:0]  modifier_bits;
   logic [TIME_W-1:0]     time_now;

   modport source (output valid, kind, scan_index, key_level, modifier_bits, time_now,
                   input ready);
   modport sink   (input valid, kind, scan_index, key_level, modifier_bits, time_now,
                   output ready);
endinterface

interface kst_rsp_if;
   import kst_pkg::*;
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   key_code;
   logic [LEVEL_W-1:0]  event_level;
   logic                last;

   modport source (output valid, key_code, event_level, last, input ready);
   modport sink   (input valid, key_code, event_level, last, output ready);
endinterface

// File: rtl/core/keyboard_scan_typematic.sv
// Keyboard matrix scanner: typematic auto-repeat per key and modifier edge events.
// Accepted items are registered in stage one (store read, decide), results in the output
// register. Key samples: one per cycle while the output register is free; a modifier
// sample stays in stage one until its modifier events have left one at a time through it.
// Reset: synchronous; level and deadline stores read as zero via per-entry valid bits,
// modifiers cleared, repeat delay 300 and interval 150.
module keyboard_scan_typematic (
   input  logic                         clock,
   input  logic                         reset,
   kst_req_if.sink                      req_chan,
   kst_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  kst_pkg::csr_index_type       csr_index,
   input  logic [kst_pkg::CSR_W-1:0]    csr_wdata
);
   import kst_pkg::*;

   logic [CSR_W-1:0]   delay_ff;
   logic [CSR_W-1:0]   interval_ff;
   logic [MOD_W-1:0]   mod_state_ff;
   logic [MOD_W-1:0]   mod_fold;
   logic               s1_valid_ff;
   stage_type          s1_ff;
   stage_type          s1_new;
   logic               rsp_valid_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_last_ff;
   logic               out_free;
   logic               s1_fire;
   logic               s1_done;
   logic               accept;
   logic               key_emit;
   logic [MOD_W-1:0]   mod_sel;
   logic [MOD_W-1:0]   mod_rest;
   logic [CODE_W-1:0]  mod_code;
   logic               emit;
   logic [CODE_W-1:0]  emit_code;
   logic [LEVEL_W-1:0] emit_level;
   logic               emit_last;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire  = s1_valid_ff && out_free;
   assign s1_done  = s1_fire && ((s1_ff.kind == KIND_KEY) || (mod_rest == '0));
   assign req_chan.ready = !s1_valid_ff || s1_done;
   assign accept   = req_chan.valid && req_chan.ready;

   // stage zero: fold modifiers, translate, precompute both deadlines
   always_comb begin
      mod_fold[0] = |(req_chan.modifier_bits & MASK_SHIFT);
      mod_fold[1] = |(req_chan.modifier_bits & MASK_CTRL);
      mod_fold[2] = |(req_chan.modifier_bits & MASK_ALT);
      s1_new.kind        = kind_type'(req_chan.kind);
      s1_new.idx         = KEY_AW'(req_chan.scan_index);
      s1_new.lvl         = req_chan.key_level;
      s1_new.code        = key_code_of(req_chan.scan_index);
      s1_new.now         = req_chan.time_now;
      s1_new.dl_delay    = req_chan.time_now + TIME_W'(delay_ff);
      s1_new.dl_interval = req_chan.time_now + TIME_W'(interval_ff);
      s1_new.mod_new     = mod_fold;
      s1_new.mod_pend    = mod_fold ^ mod_state_ff;
   end

   kst_key_unit u_key (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_idx (s1_new.idx),
      .stage  (s1_ff),
      .commit (s1_fire && (s1_ff.kind == KIND_KEY)),
      .emit   (key_emit)
   );

   // modifier events leave in the order shift, ctrl, alt
   always_comb begin
      if ((s1_ff.mod_pend & MOD_SHIFT) != '0) begin
         mod_sel  = MOD_SHIFT;
         mod_code = CODE_SHIFT;
      end else if ((s1_ff.mod_pend & MOD_CTRL) != '0) begin
         mod_sel  = MOD_CTRL;
         mod_code = CODE_CTRL;
      end else begin
         mod_sel  = MOD_ALT;
         mod_code = CODE_ALT;
      end
      mod_rest = s1_ff.mod_pend & ~mod_sel;
      if (s1_ff.kind == KIND_KEY) begin
         emit       = key_emit;
         emit_code  = s1_ff.code;
         emit_level = s1_ff.lvl;
         emit_last  = 1'b1;
      end else begin
         emit       = s1_ff.mod_pend != '0;
         emit_code  = mod_code;
         emit_level = LEVEL_W'((s1_ff.mod_new & mod_sel) != '0);
         emit_last  = mod_rest == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= RESET_DELAY;
         interval_ff  <= RESET_INTERVAL;
         mod_state_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REPEAT_DELAY:    delay_ff <= csr_wdata;
               CSR_REPEAT_INTERVAL: interval_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && (s1_new.kind == KIND_MOD)) begin
            mod_state_ff <= mod_fold;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_fire && emit;
         end
      end
      // advance: load a new item, or drop the modifier event just sent
      if (accept) begin
         s1_ff <= s1_new;
      end else if (s1_fire && (s1_ff.kind == KIND_MOD)) begin
         s1_ff.mod_pend <= mod_rest;
      end
      if (s1_fire && emit) begin
         rsp_code_ff  <= emit_code;
         rsp_level_ff <= emit_level;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.key_code    = rsp_code_ff;
   assign rsp_chan.event_level = rsp_level_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // a modifier item's pending set only ever loses members while it waits
   a_mod_pend_shrinks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_ff.kind == KIND_MOD) && !accept
      |=> (s1_ff.mod_pend & ~$past(s1_ff.mod_pend)) == '0)
      else $error("modifier pending set gained a member");

   // a key beat is always the final one of its item
   a_key_last: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_ff.kind == KIND_KEY) && key_emit |=> rsp_valid_ff && rsp_last_ff)
      else $error("key beat without last");

   // only modifier items produce beats that are not final, with level 0 or 1
   a_nonlast_is_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff
      |-> ((rsp_code_ff == CODE_SHIFT) || (rsp_code_ff == CODE_CTRL))
          && (rsp_level_ff[LEVEL_W-1:1] == '0))
      else $error("non-final beat not a modifier event");

   // a new item enters only when stage one is empty or finishing
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> !s1_valid_ff || s1_done)
      else $error("stage one overrun");
endmodule

// File: rtl/core/kst_ram.sv
// Generic single-port-write, registered-read RAM.
module kst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/kst_key_unit.sv
// Per-key level and deadline store: read, decide, write back with forwarding.
module kst_key_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [kst_pkg::KEY_AW-1:0] rd_idx,
   input  kst_pkg::stage_type         stage,
   input  logic                       commit,
   output logic                       emit
);
   import kst_pkg::*;

   logic [ENTRY_W-1:0]  rd_data;
   logic                wr_en;
   logic [ENTRY_W-1:0]  wr_data;
   logic [NUM_KEYS-1:0] valid_ff;
   logic [NUM_KEYS-1:0] valid_in;
   logic                fwd_hit_ff;
   logic [ENTRY_W-1:0]  fwd_data_ff;
   logic [ENTRY_W-1:0]  stored;
   logic [LEVEL_W-1:0]  stored_lvl;
   logic [TIME_W-1:0]   stored_dl;
   logic                changed;
   logic                repeat_due;

   kst_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_KEYS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (stage.idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   // an entry never written reads as zero; a write at the read edge is forwarded
   always_comb begin
      if (fwd_hit_ff) begin
         stored = fwd_data_ff;
      end else if (valid_ff[stage.idx]) begin
         stored = rd_data;
      end else begin
         stored = '0;
      end
      stored_lvl = stored[ENTRY_W-1 -: LEVEL_W];
      stored_dl  = stored[TIME_W-1:0];
      changed    = stored_lvl != stage.lvl;
      repeat_due = !changed && (stored_lvl != '0) && time_passed(stage.now, stored_dl);
      wr_en      = commit && (changed || repeat_due);
      wr_data    = changed ? {stage.lvl, stage.dl_delay} : {stored_lvl, stage.dl_interval};
      emit       = (changed || repeat_due) && (stage.code != '0);
      valid_in   = valid_ff;
      if (wr_en) begin
         valid_in[stage.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fwd_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            fwd_hit_ff <= wr_en && (stage.idx == rd_idx);
         end
      end
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end
endmodule
